### sv/lsos_pkg.sv
package lsos_pkg;

  // Scan geometry
  localparam int unsigned SCAN_LENGTH = 721;
  localparam int unsigned IDX_W       = $clog2(SCAN_LENGTH);

  localparam logic [IDX_W-1:0] RIGHT_LO = IDX_W'(0);
  localparam logic [IDX_W-1:0] RIGHT_HI = IDX_W'(143);
  localparam logic [IDX_W-1:0] FRONT_LO = IDX_W'(288);
  localparam logic [IDX_W-1:0] FRONT_HI = IDX_W'(431);
  localparam logic [IDX_W-1:0] LEFT_LO  = IDX_W'(576);
  localparam logic [IDX_W-1:0] LEFT_HI  = IDX_W'(713);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LENGTH - 1);

  // Field widths
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned RATE_W  = 11;
  localparam int unsigned OP_W    = 2;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [RANGE_W-1:0] CLIP_RST       = RANGE_W'(3000);
  localparam logic [RANGE_W-1:0] FRONT_LIM_RST  = RANGE_W'(1500);
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = SPEED_W'(300);
  localparam logic [SPEED_W-1:0] SPEED_STEP_RST = SPEED_W'(20);
  localparam logic [SPEED_W-1:0] TURN_SPEED_RST = SPEED_W'(20);
  localparam logic [SPEED_W-1:0] TURN_RATE_RST  = SPEED_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_FASTER = 2'd1,
    OP_SLOWER = 2'd2
  } op_e;

  typedef enum logic {
    KIND_DRIVE = 1'b0,
    KIND_SPEED = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP       = 3'd0,
    REG_FRONT_LIM  = 3'd1,
    REG_MAX_SPEED  = 3'd2,
    REG_SPEED_STEP = 3'd3,
    REG_TURN_SPEED = 3'd4,
    REG_TURN_RATE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [RANGE_W-1:0] clip_distance;
    logic [RANGE_W-1:0] front_limit;
    logic [SPEED_W-1:0] max_speed;
    logic [SPEED_W-1:0] speed_step;
    logic [SPEED_W-1:0] turn_speed;
    logic [SPEED_W-1:0] turn_rate;
  } cfg_t;

  typedef struct packed {
    kind_e                     kind;
    logic [SPEED_W-1:0]        linear_speed;
    logic signed [RATE_W-1:0]  angular_rate;
    logic [SPEED_W-1:0]        speed_now;
  } res_t;

endpackage

### sv/lsos_cfg_regs.sv
module lsos_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [lsos_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [lsos_pkg::CFG_DATA_W-1:0] wr_data_i,
  output lsos_pkg::cfg_t                cfg_o
);
  import lsos_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        REG_CLIP:       cfg_d.clip_distance = wr_data_i[RANGE_W-1:0];
        REG_FRONT_LIM:  cfg_d.front_limit   = wr_data_i[RANGE_W-1:0];
        REG_MAX_SPEED:  cfg_d.max_speed     = wr_data_i[SPEED_W-1:0];
        REG_SPEED_STEP: cfg_d.speed_step    = wr_data_i[SPEED_W-1:0];
        REG_TURN_SPEED: cfg_d.turn_speed    = wr_data_i[SPEED_W-1:0];
        REG_TURN_RATE:  cfg_d.turn_rate     = wr_data_i[SPEED_W-1:0];
        default: ; // no register there
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_distance <= CLIP_RST;
      cfg_q.front_limit   <= FRONT_LIM_RST;
      cfg_q.max_speed     <= MAX_SPEED_RST;
      cfg_q.speed_step    <= SPEED_STEP_RST;
      cfg_q.turn_speed    <= TURN_SPEED_RST;
      cfg_q.turn_rate     <= TURN_RATE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/lsos_core.sv
module lsos_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsos_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lsos_pkg::OP_W-1:0]     in_op_i,
  input  logic [lsos_pkg::RANGE_W-1:0]  in_range_i,
  input  logic                          res_room_i,
  output logic                          res_push_o,
  output lsos_pkg::res_t                res_o
);
  import lsos_pkg::*;

  // input register
  logic               in_valid_q;
  logic [OP_W-1:0]    op_q;
  logic [RANGE_W-1:0] range_q;

  // scan and speed state
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [RANGE_W-1:0] right_q, right_d;
  logic [RANGE_W-1:0] front_q, front_d;
  logic [RANGE_W-1:0] left_q, left_d;
  logic [SPEED_W-1:0] speed_q, speed_d;

  logic               is_sample, is_faster, is_slower;
  logic               is_last, has_res, adv;
  logic [RANGE_W-1:0] right_base, front_base, left_base;
  logic [SPEED_W:0]   speed_sum;
  res_t               res;

  assign is_sample = (op_e'(op_q) == OP_SAMPLE);
  assign is_faster = (op_e'(op_q) == OP_FASTER);
  assign is_slower = (op_e'(op_q) == OP_SLOWER);
  assign is_last   = (idx_q == LAST_IDX);
  assign has_res   = is_faster || is_slower || (is_sample && is_last);
  assign adv       = in_valid_q && (!has_res || res_room_i);

  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q    <= in_op_i;
      range_q <= in_range_i;
    end
  end

  always_comb begin
    // minima restart from the clip distance at the first sample of a scan
    right_base = (idx_q == '0) ? cfg_i.clip_distance : right_q;
    front_base = (idx_q == '0) ? cfg_i.clip_distance : front_q;
    left_base  = (idx_q == '0) ? cfg_i.clip_distance : left_q;

    right_d = right_base;
    front_d = front_base;
    left_d  = left_base;
    // right sector starts at index 0, only its upper bound needs a compare
    if (idx_q < RIGHT_HI && range_q < right_base) right_d = range_q;
    if (idx_q >= FRONT_LO && idx_q < FRONT_HI && range_q < front_base) front_d = range_q;
    if (idx_q >= LEFT_LO && idx_q < LEFT_HI && range_q < left_base)    left_d  = range_q;

    idx_d = is_last ? '0 : idx_q + IDX_W'(1);

    speed_sum = {1'b0, speed_q} + {1'b0, cfg_i.speed_step};
    speed_d   = speed_q;
    if (is_faster) begin
      speed_d = (speed_sum > {1'b0, cfg_i.max_speed}) ? cfg_i.max_speed
                                                       : speed_sum[SPEED_W-1:0];
    end else if (is_slower) begin
      speed_d = (cfg_i.speed_step > speed_q) ? '0 : speed_q - cfg_i.speed_step;
    end

    res = '0;
    if (is_sample) begin
      res.kind = KIND_DRIVE;
      if (front_d < cfg_i.front_limit) begin
        if (left_d < right_d) begin
          res.linear_speed = cfg_i.turn_speed;
          res.angular_rate = -$signed({1'b0, cfg_i.turn_rate});
        end else if (right_d < left_d) begin
          res.linear_speed = cfg_i.turn_speed;
          res.angular_rate = $signed({1'b0, cfg_i.turn_rate});
        end
      end else begin
        res.linear_speed = speed_q;
      end
    end else begin
      res.kind      = KIND_SPEED;
      res.speed_now = speed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      right_q <= CLIP_RST;
      front_q <= CLIP_RST;
      left_q  <= CLIP_RST;
      speed_q <= '0;
    end else if (adv) begin
      if (is_sample) begin
        idx_q   <= idx_d;
        right_q <= right_d;
        front_q <= front_d;
        left_q  <= left_d;
      end
      speed_q <= speed_d;
    end
  end

  assign res_push_o = adv && has_res;
  assign res_o      = res;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX)
    else $error("sample index beyond scan");

  a_scan_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_sample && is_last |=> idx_q == '0)
    else $error("scan did not wrap after last sample");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> res_room_i)
    else $error("result pushed without room");

  a_faster_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_faster |=> speed_q <= $past(cfg_i.max_speed))
    else $error("set speed above max after speed up");

endmodule

### sv/lsos_out_buf.sv
module lsos_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsos_pkg::res_t push_data_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lsos_pkg::res_t out_data_o
);
  import lsos_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic pop;

  assign pop    = out_valid_q && out_ready_i;
  assign room_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item ahead of the output register");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && skid_valid_q |=> out_valid_q && !skid_valid_q)
    else $error("skid item lost on drain");

endmodule

### sv/lidar_sector_obstacle_steer_top.sv
// Channel  | Dir | Handshake             | Payload
// s_axis   | in  | tvalid/tready         | tuser: operation; tdata: range_mm
// m_axis   | out | tvalid/tready         | tuser: kind; tdata: linear_speed,
//          |     |                       |   angular_rate, speed_now
// cfg      | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while the skid entry has room. An accepted item
// is held in the input register, then its state update and result go through one
// level of logic into a two-entry output buffer (output register plus skid), from
// which a result is presented once its item leaves the input register.
// s_axis_tready depends only on registered state; it drops when the input
// register holds an item with a result and the skid entry is full.
// Reset zeroes the scan index, set speed and valid flags and returns the config
// registers to their defaults.
module lidar_sector_obstacle_steer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [lsos_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // [15:0] range_mm
  input  logic [lsos_pkg::IN_USER_W-1:0]   s_axis_tuser_i,  // [1:0] operation
  // master stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [9:0] linear_speed, [20:10] angular_rate, [30:21] speed_now, [31] zero
  output logic [lsos_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic [lsos_pkg::OUT_USER_W-1:0]  m_axis_tuser_o,  // [0] kind
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lsos_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lsos_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lsos_pkg::*;

  cfg_t cfg;
  res_t res, out_res;
  logic res_push, res_room;

  assign cfg_ready_o = 1'b1;

  lsos_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  lsos_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (s_axis_tuser_i[OP_W-1:0]),
    .in_range_i (s_axis_tdata_i[RANGE_W-1:0]),
    .res_room_i (res_room),
    .res_push_o (res_push),
    .res_o      (res)
  );

  lsos_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .room_o      (res_room),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  // pack result fields, lowest first
  assign m_axis_tdata_o = {1'b0, out_res.speed_now, out_res.angular_rate,
                           out_res.linear_speed};
  assign m_axis_tuser_o = out_res.kind;

endmodule

### test/lidar_sector_obstacle_steer_top_test.sv
`timescale 1ns / 100ps

module lidar_sector_obstacle_steer_top_test;
  import lsos_pkg::*;

  // Scan geometry, sector spans are half open [lo, hi)
  localparam int unsigned SCAN_LEN = 721;
  localparam int unsigned R_LO     = 0;
  localparam int unsigned R_HI     = 143;
  localparam int unsigned F_LO     = 288;
  localparam int unsigned F_HI     = 431;
  localparam int unsigned L_LO     = 576;
  localparam int unsigned L_HI     = 713;

  // Operation code the block has no use for
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned LONG_IDLE   = 40;        // longest random gap or stall
  localparam int unsigned LONG_HOLD   = 300;       // receiver hold-off for back-pressure
  localparam int unsigned SETTLE      = 8;         // margin for the pipe to empty
  localparam int unsigned MAX_SHOWN   = 30;        // mismatch lines printed
  // ~1850 items, worst case each waits a long gap plus the pipe, results the longest
  // stall; the limit leaves ample margin over that worst case.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Stimulus shapes for one scan
  typedef enum int unsigned {
    SC_CLEAR,        // front above limit: straight
    SC_LEFT_TIGHT,   // left nearer than right: turn right
    SC_RIGHT_TIGHT,  // right nearer than left: turn left
    SC_EVEN,         // both sides the same
    SC_AT_LIMIT,     // front minimum exactly at limit
    SC_NOISE
  } scan_kind_e;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [RANGE_W-1:0] range_mm;
  } item_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // DUT side signals
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lidar_sector_obstacle_steer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Predictor state: register copy, scan position, sector minima, set speed
  cfg_t               regs;
  logic [9:0]         scan_pos;
  logic [RANGE_W-1:0] min_right;
  logic [RANGE_W-1:0] min_front;
  logic [RANGE_W-1:0] min_left;
  logic [SPEED_W-1:0] speed_set;

  res_t  due_commands[$];   // commands still to come out, oldest first
  item_t pending_items[$];  // items not yet offered

  // Test control and bookkeeping
  bit          burst_mode = 1'b0;  // sender offers back to back
  bit          hold_req   = 1'b0;  // one-cycle pulse starts the long hold-off
  int unsigned gen_pos    = 0;     // scan position of the next queued sample
  int unsigned gap_left, calm_tx, hold_left, stall_left, calm_rx;
  int unsigned cycle_cnt  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_items    = 0;
  int unsigned n_cfg      = 0;
  int unsigned n_speed    = 0;
  int unsigned n_straight = 0;
  int unsigned n_left     = 0;
  int unsigned n_right    = 0;
  int unsigned n_stop     = 0;
  int unsigned n_in_stall = 0;
  bit          offering;
  item_t       next_item;

  function automatic bit in_span(input int unsigned idx, input int unsigned lo,
                                 input int unsigned hi);
    return idx >= lo && idx < hi;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, LONG_IDLE);
  endfunction

  // Sector boundaries and random spots inside
  function automatic int unsigned pick_pos(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi - 1;
    return $urandom_range(lo, hi - 1);
  endfunction

  // A sample no lower than the sector's intended minimum
  function automatic logic [RANGE_W-1:0] above_floor(input logic [RANGE_W-1:0] t);
    if ($urandom_range(0, 7) == 0) return t;
    return RANGE_W'(t + $urandom_range(0, 16'hFFFF - t));
  endfunction

  task automatic note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_SHOWN) $display("%0t ERROR: %s", $time, msg);
  endtask

  // Next state and command for one accepted item
  task automatic compute_command(input logic [OP_W-1:0] op,
                                 input logic [RANGE_W-1:0] range_mm);
    res_t             cmd;
    logic [SPEED_W:0] sum;
    cmd = '0;
    case (op)
      OP_FASTER: begin
        sum = {1'b0, speed_set} + {1'b0, regs.speed_step};
        if (sum > {1'b0, regs.max_speed}) sum = {1'b0, regs.max_speed};
        speed_set     = sum[SPEED_W-1:0];
        cmd.kind      = KIND_SPEED;
        cmd.speed_now = speed_set;
        due_commands.push_back(cmd);
        n_speed++;
      end
      OP_SLOWER: begin
        // floors at zero, no clamp to max_speed
        speed_set     = (regs.speed_step > speed_set) ? '0 : speed_set - regs.speed_step;
        cmd.kind      = KIND_SPEED;
        cmd.speed_now = speed_set;
        due_commands.push_back(cmd);
        n_speed++;
      end
      OP_SAMPLE: begin
        // minima reload at scan start, so a clip write lands on the next scan
        if (scan_pos == 0) begin
          min_right = regs.clip_distance;
          min_front = regs.clip_distance;
          min_left  = regs.clip_distance;
        end
        if (in_span(scan_pos, R_LO, R_HI) && range_mm < min_right) min_right = range_mm;
        if (in_span(scan_pos, F_LO, F_HI) && range_mm < min_front) min_front = range_mm;
        if (in_span(scan_pos, L_LO, L_HI) && range_mm < min_left)  min_left  = range_mm;
        if (scan_pos == SCAN_LEN - 1) begin
          scan_pos = '0;
          cmd.kind = KIND_DRIVE;
          if (min_front < regs.front_limit) begin
            if (min_left < min_right) begin
              cmd.linear_speed = regs.turn_speed;
              cmd.angular_rate = -$signed({1'b0, regs.turn_rate});
              n_right++;
            end else if (min_right < min_left) begin
              cmd.linear_speed = regs.turn_speed;
              cmd.angular_rate = $signed({1'b0, regs.turn_rate});
              n_left++;
            end else begin
              n_stop++;
            end
          end else begin
            cmd.linear_speed = speed_set;
            n_straight++;
          end
          due_commands.push_back(cmd);
        end else begin
          scan_pos = scan_pos + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_command(input kind_e kind, input logic [OUT_DATA_W-1:0] data);
    res_t want;
    if (due_commands.size() == 0) begin
      note_mismatch($sformatf("result with none expected: kind %0d tdata %h", kind, data));
      return;
    end
    want = due_commands.pop_front();
    if (kind !== want.kind)
      note_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
    if (data[9:0] !== want.linear_speed)
      note_mismatch($sformatf("linear_speed %0d, expected %0d", data[9:0],
                              want.linear_speed));
    if ($signed(data[20:10]) !== want.angular_rate)
      note_mismatch($sformatf("angular_rate %0d, expected %0d", $signed(data[20:10]),
                              want.angular_rate));
    if (data[30:21] !== want.speed_now)
      note_mismatch($sformatf("speed_now %0d, expected %0d", data[30:21], want.speed_now));
    if (data[31] !== 1'b0)
      note_mismatch("tdata pad bit not zero");
  endtask

  // Sender: offers queued items, predicts on each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
      calm_tx  = 0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && !s_tready) n_in_stall++;
      if (s_tvalid && s_tready) begin
        compute_command(s_tuser, s_tdata);
        n_items++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_item.op;
          s_tdata  <= next_item.range_mm;
          if (burst_mode) begin
            gap_left = 0;
          end else if (calm_tx > 0) begin
            calm_tx--;
            gap_left = 0;
          end else begin
            if ($urandom_range(0, 199) == 0) calm_tx = $urandom_range(50, 300);
            gap_left = idle_len();
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and the long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
      calm_rx    = 0;
    end else begin
      if (m_tvalid && m_tready) check_command(kind_e'(m_tuser[0]), m_tdata);
      if (hold_req) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (calm_rx > 0) begin
          calm_rx--;
        end else begin
          if ($urandom_range(0, 199) == 0) calm_rx = $urandom_range(50, 300);
          stall_left = idle_len();
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ERROR: timed out after %0d cycles, %0d results outstanding",
               cycle_cnt, due_commands.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until everything queued has been sent and answered, then let the pipe empty
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_tvalid || due_commands.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CLIP:       regs.clip_distance = val;
      REG_FRONT_LIM:  regs.front_limit   = val;
      REG_MAX_SPEED:  regs.max_speed     = val[SPEED_W-1:0];
      REG_SPEED_STEP: regs.speed_step    = val[SPEED_W-1:0];
      REG_TURN_SPEED: regs.turn_speed    = val[SPEED_W-1:0];
      REG_TURN_RATE:  regs.turn_rate     = val[SPEED_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // Queue samples up to the end of the current scan, with speed and unused items mixed in.
  // Sector minima are steered toward one turn outcome per scan.
  task automatic queue_scan();
    logic [RANGE_W-1:0] tgt_r, tgt_f, tgt_l, lo_v, hi_v, top, v;
    int unsigned        pos_r, pos_f, pos_l, r;
    scan_kind_e         shape;
    bit                 traps;
    shape = scan_kind_e'($urandom_range(0, 5));
    traps = $urandom_range(0, 1);
    // half the scans keep side targets under the clip so they matter
    top  = ($urandom_range(0, 1) && regs.clip_distance > 1) ? regs.clip_distance - 1 :
           16'hFFFF;
    lo_v = $urandom_range(0, top - 1);
    hi_v = $urandom_range(lo_v + 1, top);
    case (shape)
      SC_LEFT_TIGHT:  begin tgt_l = lo_v; tgt_r = hi_v; end
      SC_RIGHT_TIGHT: begin tgt_r = lo_v; tgt_l = hi_v; end
      SC_EVEN:        begin tgt_r = lo_v; tgt_l = lo_v; end
      default:        begin tgt_r = 16'($urandom); tgt_l = 16'($urandom); end
    endcase
    case (shape)
      SC_CLEAR:    tgt_f = $urandom_range(regs.front_limit, 16'hFFFF);
      SC_AT_LIMIT: tgt_f = regs.front_limit;
      SC_NOISE:    tgt_f = 16'($urandom);
      default:     tgt_f = (regs.front_limit == 0) ? 16'd0 :
                           $urandom_range(0, regs.front_limit - 1);
    endcase
    pos_r = pick_pos(R_LO, R_HI);
    pos_f = pick_pos(F_LO, F_HI);
    pos_l = pick_pos(L_LO, L_HI);
    do begin
      r = $urandom_range(0, 99);
      if (r < 4)      pending_items.push_back('{OP_FASTER, 16'($urandom)});
      else if (r < 8) pending_items.push_back('{OP_SLOWER, 16'($urandom)});
      else if (r < 9) pending_items.push_back('{OP_UNUSED, 16'($urandom)});
      if (in_span(gen_pos, R_LO, R_HI))
        v = (gen_pos == pos_r) ? tgt_r : above_floor(tgt_r);
      else if (in_span(gen_pos, F_LO, F_HI))
        v = (gen_pos == pos_f) ? tgt_f : above_floor(tgt_f);
      else if (in_span(gen_pos, L_LO, L_HI))
        v = (gen_pos == pos_l) ? tgt_l : above_floor(tgt_l);
      else if (traps && (gen_pos == R_HI || gen_pos == F_LO - 1 || gen_pos == F_HI ||
                         gen_pos == L_LO - 1 || gen_pos == L_HI || gen_pos == SCAN_LEN - 1))
        v = '0;  // zero just outside a sector must not reach any minimum
      else
        v = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom);
      pending_items.push_back('{OP_SAMPLE, v});
      gen_pos = (gen_pos + 1) % SCAN_LEN;
    end while (gen_pos != 0);
  endtask

  // One register setting, then whole scans under it
  task automatic run_phase(input int unsigned clip, input int unsigned limit,
                           input int unsigned vmax, input int unsigned step,
                           input int unsigned tspeed, input int unsigned trate,
                           input int unsigned scans);
    write_reg(REG_CLIP,       CFG_DATA_W'(clip));
    write_reg(REG_FRONT_LIM,  CFG_DATA_W'(limit));
    write_reg(REG_MAX_SPEED,  CFG_DATA_W'(vmax));
    write_reg(REG_SPEED_STEP, CFG_DATA_W'(step));
    write_reg(REG_TURN_SPEED, CFG_DATA_W'(tspeed));
    write_reg(REG_TURN_RATE,  CFG_DATA_W'(trate));
    @(negedge clk_i);
    repeat (scans) queue_scan();
    drain();
  endtask

  // New speed limits, then a run of speed items only
  task automatic speed_phase(input int unsigned vmax, input int unsigned step,
                             input int unsigned n);
    write_reg(REG_MAX_SPEED,  CFG_DATA_W'(vmax));
    write_reg(REG_SPEED_STEP, CFG_DATA_W'(step));
    @(negedge clk_i);
    repeat (n)
      pending_items.push_back('{($urandom_range(0, 1) ? OP_FASTER : OP_SLOWER),
                                16'($urandom)});
    drain();
  endtask

  initial begin
    // predictor after reset
    regs.clip_distance = 16'd3000;
    regs.front_limit   = 16'd1500;
    regs.max_speed     = 10'd300;
    regs.speed_step    = 10'd20;
    regs.turn_speed    = 10'd20;
    regs.turn_rate     = 10'd100;
    scan_pos  = '0;
    min_right = 16'd3000;
    min_front = 16'd3000;
    min_left  = 16'd3000;
    speed_set = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: speed floor and steps, unused op, range extremes, clamp at max
    pending_items.push_back('{OP_SLOWER, 16'hFFFF});
    pending_items.push_back('{OP_FASTER, 16'h0000});
    pending_items.push_back('{OP_FASTER, 16'hFFFF});
    pending_items.push_back('{OP_SLOWER, 16'h5A5A});
    pending_items.push_back('{OP_UNUSED, 16'hFFFF});
    pending_items.push_back('{OP_SAMPLE, 16'h0000});
    pending_items.push_back('{OP_SAMPLE, 16'hFFFF});
    pending_items.push_back('{OP_SAMPLE, 16'h5555});
    pending_items.push_back('{OP_SAMPLE, 16'hAAAA});
    gen_pos = 4;
    repeat (15) pending_items.push_back('{OP_FASTER, 16'($urandom)});
    drain();

    // Back-pressure: receiver holds off while speed items stream in back to back
    @(negedge clk_i);
    burst_mode = 1'b1;
    hold_req   = 1'b1;
    repeat (48)
      pending_items.push_back('{($urandom_range(0, 1) ? OP_FASTER : OP_SLOWER),
                                16'($urandom)});
    @(negedge clk_i);
    hold_req = 1'b0;
    drain();
    burst_mode = 1'b0;

    // Finish the scan begun above under the reset settings
    run_phase(3000, 1500, 300, 20, 20, 100, 1);

    // Speed limits at their extremes
    speed_phase(1000, 1000, 40);   // one step spans the whole range
    speed_phase(0, 0, 40);         // set speed pinned at zero
    speed_phase(1000, 1, 40);
    speed_phase(100, 300, 40);     // step larger than the maximum
    speed_phase($urandom_range(0, 1000), $urandom_range(0, 1000), 40);

    // One full scan under random settings
    run_phase($urandom_range(100, 8000), $urandom_range(0, 10000),
              $urandom_range(0, 1000), $urandom_range(0, 200),
              $urandom_range(0, 1000), $urandom_range(0, 1000), 1);

    $display("Run covered %0d items and %0d register writes: %0d speed replies,",
             n_items, n_cfg, n_speed);
    $display("drive commands %0d straight, %0d left, %0d right, %0d stop; input stalled %0d cycles",
             n_straight, n_left, n_right, n_stop, n_in_stall);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
sv/lsos_pkg.sv
sv/lsos_cfg_regs.sv
sv/lsos_core.sv
sv/lsos_out_buf.sv
sv/lidar_sector_obstacle_steer_top.sv
test/lidar_sector_obstacle_steer_top_test.sv
